// File: design/dac_pkg.sv
// Shared constants, register indexes and the 2^f table for the avoided crossing evaluator.
`timescale 1ns / 1ps
package dac_pkg;
	localparam int FRAC_BITS = 24;
	localparam int DATA_W = 32;
	localparam int NUM_LANES = 2;
	localparam int OUT_W = 6 * DATA_W;
	localparam int EXP_ADDR_W = 8;
	localparam int EXP_DEPTH = 1 << EXP_ADDR_W;
	localparam int CFG_IDX_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WELL_DEPTH      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WELL_WIDTH      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COUPLING_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_OFFSET   = 3'd4;

	// Register values after reset, Q8.24.
	localparam logic [DATA_W-1:0] RST_WELL_DEPTH      = 32'd1677722;
	localparam logic [DATA_W-1:0] RST_WELL_WIDTH      = 32'd469762;
	localparam logic [DATA_W-1:0] RST_COUPLING_HEIGHT = 32'd251658;
	localparam logic [DATA_W-1:0] RST_COUPLING_WIDTH  = 32'd1006633;
	localparam logic [DATA_W-1:0] RST_ENERGY_OFFSET   = 32'd838861;

	// log2(e) in Q2.30 and ln(2) in Q0.48.
	localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
	localparam logic [47:0] LN2_Q48 = 48'hB17217F7D1CF;

	typedef logic [DATA_W-1:0] exp_tab_t [0:EXP_DEPTH];

	// Table of 2^(i/EXP_DEPTH) in Q2.30, from a 25-term series at 48 fraction bits.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] sum;
		logic [127:0] prod;
		for (int i = 0; i <= EXP_DEPTH; i++) begin
			z = (64'(i) * 64'(LN2_Q48) + 64'(EXP_DEPTH / 2)) / 64'(EXP_DEPTH);
			term = 64'd1 << 48;
			sum = term;
			for (int n = 1; n <= 24; n++) begin
				prod = 128'(term) * 128'(z) + (128'd1 << 47);
				term = prod[111:48] / 64'(n);
				sum = sum + term;
			end
			tab[i] = DATA_W'((sum + (64'd1 << 17)) >> 18);
		end
		return tab;
	endfunction
endpackage

// File: design/dual_avoided_crossing_eval.sv
// Dual avoided crossing Hamiltonian evaluator: twelve-stage pipeline with an output skid.
// Throughput: one item per cycle while s_tready is high; the depth is set by the chain of
// multiplier stages (square, exponent, table interpolation, amplitude, slope, curvature).
// On a stalled result the pipeline advances once more into the skid entry, then holds and
// drops s_tready until the output drains. Reset clears all valid bits and loads defaults.
`timescale 1ns / 1ps
module dual_avoided_crossing_eval (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [dac_pkg::DATA_W-1:0]       s_tdata,   // position
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// upper_energy, upper_slope, upper_curvature, coupling_value, coupling_slope,
	// coupling_curvature
	output logic [dac_pkg::OUT_W-1:0]        m_tdata,
	output logic [0:0]                       m_tuser,   // saturated
	input  logic                             cfg_wen,
	input  logic [dac_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dac_pkg::DATA_W-1:0]       cfg_data
);
	import dac_pkg::*;

	localparam int NSTG = 12;
	localparam exp_tab_t EXP2_TAB = build_exp_tab();
	localparam logic [NUM_LANES-1:0] LANE_NEG = 2'b10;

	// Configuration: lane 0 is the diagonal well, lane 1 the coupling.
	logic [DATA_W-1:0] amp_q [NUM_LANES];
	logic [DATA_W-1:0] wid_q [NUM_LANES];
	logic [DATA_W-1:0] offset_q;

	logic [DATA_W-1:0] wmag [NUM_LANES];
	logic              wneg [NUM_LANES];
	logic [DATA_W-1:0] amag [NUM_LANES];

	logic            en;
	logic [NSTG:1]   vld_q;

	// Stage registers.
	logic [63:0] xsq_s1;
	logic [63:0] bxp_s1 [NUM_LANES];
	logic        xneg_s1;
	logic [70:0] argp_s2 [NUM_LANES];
	logic [61:0] yp_s3 [NUM_LANES];
	logic        yneg_s3 [NUM_LANES];
	logic [31:0] t0_s4 [NUM_LANES];
	logic [31:0] diff_s4 [NUM_LANES];
	logic [23:0] wgt_s4 [NUM_LANES];
	logic [8:0]  k_s4 [NUM_LANES];
	logic [55:0] ip_s5 [NUM_LANES];
	logic [31:0] t0_s5 [NUM_LANES];
	logic [8:0]  k_s5 [NUM_LANES];
	logic [63:0] pp_s6 [NUM_LANES];
	logic [8:0]  k_s6 [NUM_LANES];
	logic [70:0] pse_s8 [NUM_LANES];
	logic [63:0] pbe_s8 [NUM_LANES];
	logic        sse_s8 [NUM_LANES];
	logic        sbe_s8 [NUM_LANES];
	logic [47:0] slm_s9 [NUM_LANES];
	logic        sln_s9 [NUM_LANES];
	logic [40:0] t1m_s9 [NUM_LANES];
	logic        t1n_s9 [NUM_LANES];
	logic [62:0] pl_s10 [NUM_LANES];
	logic [62:0] ph_s10 [NUM_LANES];
	logic [47:0] slm_s10 [NUM_LANES];
	logic        sln_s10 [NUM_LANES];
	logic [40:0] t1m_s10 [NUM_LANES];
	logic        t1n_s10 [NUM_LANES];
	logic [63:0] slope_s11 [NUM_LANES];
	logic [63:0] curv_s11 [NUM_LANES];
	logic [OUT_W-1:0] data_s12;
	logic        sat_s12;

	// Scaled position magnitude and sign travel from stage 2 through stage 10.
	logic [38:0] bxm_s [2:10][NUM_LANES];
	logic        bxn_s [2:10][NUM_LANES];
	// Gaussian terms travel from stage 7 through stage 11.
	logic [DATA_W-1:0] e_s [7:11][NUM_LANES];
	logic        gsat_s [7:11][NUM_LANES];

	// Combinational stage logic.
	logic [DATA_W-1:0] ax;
	logic [63:0] xsq_r;
	logic [38:0] xx;
	logic [63:0] bxr [NUM_LANES];
	logic [70:0] argr [NUM_LANES];
	logic [30:0] rc [NUM_LANES];
	logic [61:0] yr [NUM_LANES];
	logic [32:0] yv [NUM_LANES];
	logic [EXP_ADDR_W:0] idx0 [NUM_LANES];
	logic [EXP_ADDR_W:0] idx1 [NUM_LANES];
	logic [55:0] ipr [NUM_LANES];
	logic [31:0] mant [NUM_LANES];
	logic signed [9:0] sh [NUM_LANES];
	logic [5:0]  tsh [NUM_LANES];
	logic [63:0] qv [NUM_LANES];
	logic [63:0] rv [NUM_LANES];
	logic        big [NUM_LANES];
	logic [DATA_W-1:0] ev [NUM_LANES];
	logic        esat [NUM_LANES];
	logic [DATA_W-1:0] ae [NUM_LANES];
	logic [70:0] ser [NUM_LANES];
	logic [63:0] ber [NUM_LANES];
	logic [87:0] full [NUM_LANES];
	logic [63:0] r2 [NUM_LANES];
	logic [63:0] t1s [NUM_LANES];
	logic [63:0] secs [NUM_LANES];
	logic [32:0] cl [6];
	logic [63:0] energy;

	// Clip a wide signed value to 32 bits; the top bit flags a clip.
	function automatic logic [32:0] clip32(input logic [63:0] v);
		logic signed [63:0] sv;
		sv = $signed(v);
		if (sv > 64'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (sv < -64'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, v[31:0]};
	endfunction

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q[0] <= RST_WELL_DEPTH;
			wid_q[0] <= RST_WELL_WIDTH;
			amp_q[1] <= RST_COUPLING_HEIGHT;
			wid_q[1] <= RST_COUPLING_WIDTH;
			offset_q <= RST_ENERGY_OFFSET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WELL_DEPTH:      amp_q[0] <= cfg_data;
				REG_WELL_WIDTH:      wid_q[0] <= cfg_data;
				REG_COUPLING_HEIGHT: amp_q[1] <= cfg_data;
				REG_COUPLING_WIDTH:  wid_q[1] <= cfg_data;
				REG_ENERGY_OFFSET:   offset_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sign and magnitude of the lane parameters.
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			wneg[l] = wid_q[l][DATA_W-1];
			wmag[l] = wneg[l] ? (32'd0 - wid_q[l]) : wid_q[l];
			amag[l] = amp_q[l][DATA_W-1] ? (32'd0 - amp_q[l]) : amp_q[l];
		end
	end

	// The whole pipeline advances unless the skid holds an item.
	logic out_vld_q, skid_vld_q;
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic out_sat_q, skid_sat_q;

	assign en = !skid_vld_q;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-1:1], s_tvalid};
		end
	end

	// Arithmetic ahead of each register stage.
	always_comb begin
		ax = s_tdata[DATA_W-1] ? (32'd0 - s_tdata) : s_tdata;
		xsq_r = xsq_s1 + (64'd1 << 23);
		xx = xsq_r[62:24];
		for (int l = 0; l < NUM_LANES; l++) begin
			bxr[l] = bxp_s1[l] + (64'd1 << 23);
			// Exponent argument magnitude, limited to 64.
			argr[l] = argp_s2[l] + (71'd1 << 23);
			rc[l] = (argr[l][70:24] > (47'd1 << 30)) ? (31'd1 << 30) : argr[l][54:24];
			// Base-2 exponent split into integer and fraction.
			yr[l] = yp_s3[l] + (62'd1 << 29);
			yv[l] = yneg_s3[l] ? (33'd0 - {1'b0, yr[l][61:30]}) : {1'b0, yr[l][61:30]};
			idx0[l] = {1'b0, yv[l][FRAC_BITS-1 -: EXP_ADDR_W]};
			idx1[l] = idx0[l] + 1'b1;
			// Interpolated mantissa.
			ipr[l] = ip_s5[l] + (56'd1 << 23);
			mant[l] = t0_s5[l] + ipr[l][55:24];
			// Scale by 2^k with rounding.
			sh[l] = 10'sd30 - 10'($signed(k_s6[l]));
			tsh[l] = 6'(-sh[l]);
			qv[l] = pp_s6[l] >> 6'(sh[l] - 10'sd1);
			big[l] = (pp_s6[l] != 64'd0) &&
				((tsh[l] >= 6'd32) || (pp_s6[l] > (64'h1_0000_0000 >> tsh[l])));
			if (sh[l] >= 10'sd64) begin
				rv[l] = 64'd0;
			end else if (sh[l] >= 10'sd1) begin
				rv[l] = (qv[l] + 64'd1) >> 1;
			end else if (big[l]) begin
				rv[l] = 64'h1_0000_0000;
			end else begin
				rv[l] = pp_s6[l] << tsh[l];
			end
			if (amp_q[l][DATA_W-1]) begin
				esat[l] = rv[l] > 64'h8000_0000;
				ev[l] = esat[l] ? 32'h8000_0000 : (32'd0 - rv[l][31:0]);
			end else begin
				esat[l] = rv[l] > 64'h7FFF_FFFF;
				ev[l] = esat[l] ? 32'h7FFF_FFFF : rv[l][31:0];
			end
			// Derivative terms.
			ae[l] = e_s[7][l][DATA_W-1] ? (32'd0 - e_s[7][l]) : e_s[7][l];
			ser[l] = pse_s8[l] + (71'd1 << 23);
			ber[l] = pbe_s8[l] + (64'd1 << 23);
			full[l] = 88'(pl_s10[l]) + (88'(ph_s10[l]) << 24) + (88'd1 << 23);
			r2[l] = (full[l][87:24] > (64'd1 << 60)) ? (64'd1 << 60) : full[l][87:24];
			t1s[l] = t1n_s10[l] ? (64'd0 - 64'(t1m_s10[l])) : 64'(t1m_s10[l]);
			secs[l] = !(bxn_s[10][l] ^ sln_s10[l]) ? (64'd0 - (r2[l] << 1)) : (r2[l] << 1);
		end
		// Final clipping.
		energy = 64'($signed(offset_q)) - 64'($signed(e_s[11][0]));
		cl[0] = clip32(energy);
		cl[1] = clip32(slope_s11[0]);
		cl[2] = clip32(curv_s11[0]);
		cl[3] = {1'b0, e_s[11][1]};
		cl[4] = clip32(slope_s11[1]);
		cl[5] = clip32(curv_s11[1]);
	end

	// Pipeline payload registers.
	always_ff @(posedge clk) begin
		if (en) begin
			xsq_s1 <= 64'(ax) * 64'(ax);
			xneg_s1 <= s_tdata[DATA_W-1];
			for (int l = 0; l < NUM_LANES; l++) begin
				bxp_s1[l] <= 64'(wmag[l]) * 64'(ax);
				// Stage 2: square rounded, width times square.
				argp_s2[l] <= 71'(wmag[l]) * 71'(xx);
				bxm_s[2][l] <= bxr[l][62:24];
				bxn_s[2][l] <= wneg[l] ^ xneg_s1;
				// Stage 3: argument times log2(e).
				yp_s3[l] <= 62'(rc[l]) * 62'(LOG2E_Q30);
				yneg_s3[l] <= !wneg[l];
				// Stage 4: table lookup.
				t0_s4[l] <= EXP2_TAB[idx0[l]];
				diff_s4[l] <= EXP2_TAB[idx1[l]] - EXP2_TAB[idx0[l]];
				wgt_s4[l] <= {yv[l][FRAC_BITS-EXP_ADDR_W-1:0], {EXP_ADDR_W{1'b0}}};
				k_s4[l] <= yv[l][32:24];
				// Stage 5: interpolation product.
				ip_s5[l] <= 56'(diff_s4[l]) * 56'(wgt_s4[l]);
				t0_s5[l] <= t0_s4[l];
				k_s5[l] <= k_s4[l];
				// Stage 6: amplitude times mantissa.
				pp_s6[l] <= 64'(amag[l]) * 64'(mant[l]);
				k_s6[l] <= k_s5[l];
				// Stage 7: shifted and clipped Gaussian term.
				e_s[7][l] <= ev[l];
				gsat_s[7][l] <= esat[l];
				// Stage 8: slope and first curvature products.
				pse_s8[l] <= 71'(bxm_s[7][l]) * 71'(ae[l]);
				pbe_s8[l] <= 64'(wmag[l]) * 64'(ae[l]);
				sse_s8[l] <= bxn_s[7][l] ^ e_s[7][l][DATA_W-1];
				sbe_s8[l] <= wneg[l] ^ e_s[7][l][DATA_W-1];
				// Stage 9: rounded slope and first curvature term, doubled.
				slm_s9[l] <= {ser[l][70:24], 1'b0};
				sln_s9[l] <= sse_s8[l] ^ LANE_NEG[l];
				t1m_s9[l] <= {ber[l][63:24], 1'b0};
				t1n_s9[l] <= sbe_s8[l] ^ LANE_NEG[l];
				// Stage 10: second curvature term as two partial products.
				pl_s10[l] <= 63'(bxm_s[9][l]) * 63'(slm_s9[l][23:0]);
				ph_s10[l] <= 63'(bxm_s[9][l]) * 63'(slm_s9[l][47:24]);
				slm_s10[l] <= slm_s9[l];
				sln_s10[l] <= sln_s9[l];
				t1m_s10[l] <= t1m_s9[l];
				t1n_s10[l] <= t1n_s9[l];
				// Stage 11: signed slope and curvature.
				slope_s11[l] <= sln_s10[l] ? (64'd0 - 64'(slm_s10[l])) : 64'(slm_s10[l]);
				curv_s11[l] <= t1s[l] + secs[l];
				for (int s = 3; s <= 10; s++) begin
					bxm_s[s][l] <= bxm_s[s-1][l];
					bxn_s[s][l] <= bxn_s[s-1][l];
				end
				for (int s = 8; s <= 11; s++) begin
					e_s[s][l] <= e_s[s-1][l];
					gsat_s[s][l] <= gsat_s[s-1][l];
				end
			end
			// Stage 12: clipped result item.
			data_s12 <= {cl[5][31:0], cl[4][31:0], cl[3][31:0],
				cl[2][31:0], cl[1][31:0], cl[0][31:0]};
			sat_s12 <= gsat_s[11][0] | gsat_s[11][1] | cl[0][32] | cl[1][32] |
				cl[2][32] | cl[4][32] | cl[5][32];
		end
	end

	// Output register with a skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (m_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_q[NSTG];
			end
		end else if (vld_q[NSTG] && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_tready || !out_vld_q) begin
			if (skid_vld_q) begin
				out_data_q <= skid_data_q;
				out_sat_q <= skid_sat_q;
			end else begin
				out_data_q <= data_s12;
				out_sat_q <= sat_s12;
			end
		end else if (vld_q[NSTG] && en) begin
			skid_data_q <= data_s12;
			skid_sat_q <= sat_s12;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_sat_q;
endmodule

// File: design/dac_checker.sv
// Port-level checks for the avoided crossing evaluator, bound to the top level.
`timescale 1ns / 1ps
module dac_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tready,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [dac_pkg::OUT_W-1:0] m_tdata
);
	import dac_pkg::*;

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result payload changed while stalled");

	// Reset empties the output side.
	a_reset_clear: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	// A consumer that keeps taking results never blocks the input.
	a_input_open: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |=> s_tready)
		else $error("input blocked although results are being taken");
endmodule

bind dual_avoided_crossing_eval dac_checker u_dac_checker (.*);
